// ----- hw/rtl/psgpc_pkg.sv -----
package psgpc_pkg;

  localparam int QDEPTH = 25;
  localparam int NUM_REGS = 14;

  localparam logic [3:0] REG_FREQ_C_HI = 4'd5;
  localparam logic [3:0] REG_NOISE = 4'd6;
  localparam logic [3:0] REG_MIXER = 4'd7;
  localparam logic [3:0] REG_VOL_A = 4'd8;
  localparam logic [3:0] REG_VOL_C = 4'd10;
  localparam logic [3:0] REG_PER_LO = 4'd11;
  localparam logic [3:0] REG_PER_HI = 4'd12;
  localparam logic [3:0] REG_SHAPE = 4'd13;

  localparam logic [16:0] TONE_SCALE = 17'd68719;
  localparam logic [12:0] FREQ_MAX = 13'd2048;
  localparam logic [15:0] FREQ_BASE = 16'h8800;
  localparam logic [15:0] NOISE_BASE = 16'h8000;
  localparam logic [7:0] ENV_INC = 8'h0F;
  localparam logic [7:0] ENV_ONESHOT = 8'h10;

  localparam logic [3:0] TGT_CTL2 = 4'd4;
  localparam logic [3:0] TGT_WAVE0 = 4'd6;
  localparam logic [3:0] TGT_NLEVEL = 4'd10;
  localparam logic [3:0] TGT_NFREQ = 4'd11;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SYNC, S_DIV, S_APPLY, S_EVAL, S_EMIT,
    S_WRITE, S_TONE_MUL, S_TONE_SET, S_NOISE_SET, S_DRAIN
  } state_t;

  typedef enum logic [2:0] {
    RK_IGNORE, RK_TONE, RK_NOISE, RK_MIXER, RK_VOL, RK_PERIOD, RK_SHAPE
  } kind_t;

  typedef enum logic [3:0] {
    EM_LEVEL, EM_FREQ, EM_CTL_OFF, EM_WAVE0, EM_WAVE1, EM_WAVE2, EM_WAVE3,
    EM_CTL_ON, EM_NEW_FREQ
  } emit_t;

  typedef struct packed {
    logic       accept;
    logic       div_start;
    logic       apply_sync;
    logic       wr_reg;
    logic       tone_mul;
    logic       eval;
    logic       emit;
    emit_t      code;
    logic [1:0] lane;
    logic       drain;
  } cmd_t;

  typedef struct packed {
    logic       is_sync;
    logic       ignore;
    logic       sync_need;
    logic       div_done;
    kind_t      kind;
    logic [1:0] tone_lane;
    logic       eval_hit;
    logic       lvl2_zero;
    logic       drain_end;
  } sts_t;

  function automatic logic [7:0] shape_lookup(input logic [3:0] s);
    logic [7:0] r;
    case (s)
      4'd0, 4'd1, 4'd2, 4'd3, 4'd9: r = 8'h10;
      4'd4, 4'd5, 4'd6, 4'd7, 4'd15: r = 8'h1F;
      4'd8: r = 8'h40;
      4'd10: r = 8'h00;
      4'd11: r = 8'h30;
      4'd12: r = 8'h4F;
      4'd13: r = 8'h3F;
      default: r = 8'h0F;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] noise_lookup(input logic [4:0] n);
    logic [7:0] r;
    case (n)
      5'd0: r = 8'h01;
      5'd1: r = 8'h11;
      5'd2: r = 8'h21;
      5'd3: r = 8'h13;
      5'd4: r = 8'h31;
      5'd5: r = 8'h15;
      5'd6: r = 8'h23;
      5'd7: r = 8'h17;
      5'd8: r = 8'h41;
      5'd9, 5'd10: r = 8'h25;
      5'd11, 5'd12: r = 8'h33;
      5'd13, 5'd14: r = 8'h27;
      5'd15, 5'd16: r = 8'h51;
      5'd17, 5'd18, 5'd19, 5'd20, 5'd21: r = 8'h35;
      5'd22, 5'd23, 5'd24: r = 8'h43;
      5'd25, 5'd26, 5'd27, 5'd28: r = 8'h37;
      default: r = 8'h61;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/psgpc_div.sv -----
module psgpc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [23:0] divisor,
  output logic        done,
  output logic [31:0] quotient,
  output logic [23:0] remainder
);

  logic [5:0]  cnt;
  logic [24:0] trial;

  // Restoring division, one quotient bit per cycle.
  assign trial = {remainder, quotient[31]};
  assign done = (cnt == 6'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 6'd0;
    end else if (start) begin
      cnt <= 6'd32;
    end else if (!done) begin
      cnt <= cnt - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      remainder <= 24'd0;
    end else if (!done) begin
      if (trial >= {1'b0, divisor}) begin
        remainder <= 24'(trial - {1'b0, divisor});
        quotient <= {quotient[30:0], 1'b1};
      end else begin
        remainder <= trial[23:0];
        quotient <= {quotient[30:0], 1'b0};
      end
    end
  end

endmodule

// ----- hw/rtl/psgpc_dp.sv -----
module psgpc_dp (
  input  logic               clk,
  input  logic               rst,
  input  psgpc_pkg::cmd_t    cmd,
  output psgpc_pkg::sts_t    sts,
  input  logic               operation,
  input  logic [3:0]         reg_index,
  input  logic [7:0]         reg_value,
  input  logic [31:0]        now,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_data,
  output logic               strobe,
  output logic [3:0]         target,
  output logic [31:0]        data,
  output logic               last
);

  logic [7:0]  regs [psgpc_pkg::NUM_REGS];
  logic        op_r;
  logic [3:0]  idx_r;
  logic [7:0]  val_r;
  logic [31:0] now_r;
  logic [3:0]  clock_multiple;

  logic [7:0]  env_mode;
  logic [3:0]  env_cnt;
  logic        env_stop;
  logic [3:0]  env_level;
  logic [31:0] last_clock;
  logic [23:0] env_period;
  logic [15:0] cfreq [4];
  logic [3:0]  chlev [4];
  logic        wave_bank;
  logic [5:0]  mask;

  logic [3:0]  qt [psgpc_pkg::QDEPTH];
  logic [31:0] qd [psgpc_pkg::QDEPTH];
  logic [4:0]  qcnt;
  logic [4:0]  rd;
  logic [28:0] prod;

  logic [31:0] elapsed;
  logic        div_done;
  logic [31:0] quo;
  logic [23:0] rem;

  logic [7:0]  cur;
  psgpc_pkg::kind_t kind;
  logic [3:0]  cv [3];
  logic [3:0]  nmax;
  logic [3:0]  lane_v;
  logic        lane_en;
  logic [7:0]  mix;

  logic        ap_small;
  logic [6:0]  ap_d;
  logic [3:0]  ap_cnt;
  logic [7:0]  ap_mode;
  logic [3:0]  ap_level;

  logic [7:0]  p_lo;
  logic [7:0]  p_hi;
  logic [16:0] p_full;
  logic [3:0]  mult;
  logic [20:0] pm;

  logic [7:0]  f_lo;
  logic [7:0]  f_hi;
  logic [12:0] fs;
  logic [11:0] fc;
  logic [15:0] new_freq;

  logic [3:0]  e_tgt;
  logic [31:0] e_dat;

  psgpc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (elapsed),
    .divisor   (env_period),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  assign mix = regs[psgpc_pkg::REG_MIXER];
  assign elapsed = now_r - last_clock;

  always_comb begin
    cur = (idx_r < 4'(psgpc_pkg::NUM_REGS)) ? regs[idx_r] : 8'd0;
    if (idx_r <= psgpc_pkg::REG_FREQ_C_HI) begin
      kind = psgpc_pkg::RK_TONE;
    end else if (idx_r == psgpc_pkg::REG_NOISE) begin
      kind = psgpc_pkg::RK_NOISE;
    end else if (idx_r == psgpc_pkg::REG_MIXER) begin
      kind = psgpc_pkg::RK_MIXER;
    end else if (idx_r <= psgpc_pkg::REG_VOL_C) begin
      kind = psgpc_pkg::RK_VOL;
    end else if (idx_r <= psgpc_pkg::REG_PER_HI) begin
      kind = psgpc_pkg::RK_PERIOD;
    end else if (idx_r == psgpc_pkg::REG_SHAPE) begin
      kind = psgpc_pkg::RK_SHAPE;
    end else begin
      kind = psgpc_pkg::RK_IGNORE;
    end
  end

  // Channel volumes: fixed, or the envelope level when bit 4 is set.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      cv[c] = regs[8 + c][4] ? env_level : regs[8 + c][3:0];
    end
    nmax = 4'd0;
    for (int c = 0; c < 3; c++) begin
      if (!mix[3 + c] && cv[c] > nmax) begin
        nmax = cv[c];
      end
    end
    case (cmd.lane)
      2'd0: begin
        lane_v = mix[0] ? 4'd0 : cv[0];
        lane_en = mask[0];
      end
      2'd1: begin
        lane_v = mix[1] ? 4'd0 : cv[1];
        lane_en = mask[1];
      end
      2'd2: begin
        lane_v = mix[2] ? 4'd0 : cv[2];
        lane_en = mask[2];
      end
      default: begin
        lane_v = nmax;
        lane_en = |mask[5:3];
      end
    endcase
  end

  // Envelope advance after the division. The low four bits of the counter
  // are the same whether it wraps once or twice; an odd wrap count flips
  // the direction unless mode bit 6 is set (a shape that does not alternate).
  always_comb begin
    ap_small = (quo[31:4] == 28'd0) && (quo[3:0] <= env_cnt);
    ap_d = {3'b000, env_cnt} - {2'b00, quo[4:0]};
    ap_mode = env_mode;
    if (ap_small) begin
      ap_cnt = env_cnt - quo[3:0];
      ap_level = ap_cnt ^ env_mode[3:0];
    end else begin
      ap_cnt = ap_d[3:0];
      if (ap_d[6] && ap_d[4] && !env_mode[6]) begin
        ap_mode = env_mode ^ psgpc_pkg::ENV_INC;
      end
      ap_level = ap_cnt ^ ap_mode[3:0];
    end
  end

  always_comb begin
    p_lo = (idx_r == psgpc_pkg::REG_PER_LO) ? val_r : regs[psgpc_pkg::REG_PER_LO];
    p_hi = (idx_r == psgpc_pkg::REG_PER_HI) ? val_r : regs[psgpc_pkg::REG_PER_HI];
    p_full = ({p_hi, p_lo} == 16'd0) ? 17'h10000 : {1'b0, p_hi, p_lo};
    mult = (clock_multiple == 4'd0) ? 4'd1 : clock_multiple;
    pm = {4'b0000, p_full} * {17'd0, mult};
  end

  always_comb begin
    case (idx_r[2:1])
      2'd0: begin
        f_lo = regs[0];
        f_hi = regs[1];
      end
      2'd1: begin
        f_lo = regs[2];
        f_hi = regs[3];
      end
      default: begin
        f_lo = regs[4];
        f_hi = regs[5];
      end
    endcase
    fs = prod[28:16];
    if (fs == 13'd0) begin
      fc = 12'd1;
    end else if (fs > psgpc_pkg::FREQ_MAX) begin
      fc = psgpc_pkg::FREQ_MAX[11:0];
    end else begin
      fc = fs[11:0];
    end
    if (cmd.lane == 2'd3) begin
      new_freq = psgpc_pkg::NOISE_BASE + {8'd0, psgpc_pkg::noise_lookup(val_r[4:0])};
    end else begin
      new_freq = psgpc_pkg::FREQ_BASE - {4'd0, fc};
    end
  end

  always_comb begin
    e_tgt = (cmd.lane == 2'd3) ? psgpc_pkg::TGT_NLEVEL : {1'b0, cmd.lane, 1'b0};
    e_dat = 32'd0;
    case (cmd.code)
      psgpc_pkg::EM_LEVEL: begin
        if (cmd.lane == 2'd3) begin
          e_dat = {16'd0, chlev[3], 12'h000};
        end else begin
          e_dat = {16'd0, chlev[cmd.lane], 12'h080};
        end
      end
      psgpc_pkg::EM_FREQ, psgpc_pkg::EM_NEW_FREQ: begin
        e_tgt = (cmd.lane == 2'd3) ? psgpc_pkg::TGT_NFREQ : {1'b0, cmd.lane, 1'b1};
        e_dat = {16'd0, (cmd.code == psgpc_pkg::EM_FREQ) ? cfreq[cmd.lane] : new_freq};
      end
      psgpc_pkg::EM_CTL_OFF: begin
        e_tgt = psgpc_pkg::TGT_CTL2;
      end
      psgpc_pkg::EM_WAVE0, psgpc_pkg::EM_WAVE2: begin
        e_tgt = psgpc_pkg::TGT_WAVE0 + ((cmd.code == psgpc_pkg::EM_WAVE2) ? 4'd2 : 4'd0);
        e_dat = {8{chlev[2]}};
      end
      psgpc_pkg::EM_WAVE1, psgpc_pkg::EM_WAVE3: begin
        e_tgt = psgpc_pkg::TGT_WAVE0 + ((cmd.code == psgpc_pkg::EM_WAVE3) ? 4'd3 : 4'd1);
      end
      psgpc_pkg::EM_CTL_ON: begin
        e_tgt = psgpc_pkg::TGT_CTL2;
        e_dat = {24'd0, 1'b1, wave_bank, 6'd0};
      end
      default: begin
        e_tgt = psgpc_pkg::TGT_CTL2;
      end
    endcase
  end

  always_comb begin
    sts.is_sync = op_r;
    sts.ignore = (kind == psgpc_pkg::RK_IGNORE) ||
                 ((cur == val_r) && (idx_r != psgpc_pkg::REG_SHAPE));
    sts.sync_need = !env_stop && (elapsed >= {8'd0, env_period});
    sts.div_done = div_done;
    sts.kind = kind;
    sts.tone_lane = idx_r[2:1];
    sts.eval_hit = lane_en && (chlev[cmd.lane] != lane_v);
    sts.lvl2_zero = (chlev[2] == 4'd0);
    sts.drain_end = ({1'b0, rd} + 6'd1 >= {1'b0, qcnt});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < psgpc_pkg::NUM_REGS; i++) begin
        regs[i] <= (i == int'(psgpc_pkg::REG_MIXER)) ? 8'h3F : 8'h00;
      end
      clock_multiple <= 4'd2;
      env_mode <= psgpc_pkg::ENV_ONESHOT;
      env_cnt <= 4'd15;
      env_stop <= 1'b0;
      env_level <= 4'd15;
      last_clock <= 32'd0;
      env_period <= 24'd2097152;
      for (int i = 0; i < 4; i++) begin
        cfreq[i] <= 16'd0;
        chlev[i] <= 4'd0;
      end
      wave_bank <= 1'b0;
      mask <= 6'd0;
      qcnt <= 5'd0;
      rd <= 5'd0;
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.drain && (rd < qcnt);
      if (cfg_we) begin
        clock_multiple <= cfg_data;
      end
      if (cmd.accept) begin
        qcnt <= 5'd0;
        rd <= 5'd0;
      end
      if (cmd.apply_sync) begin
        last_clock <= now_r - {8'd0, rem};
        mask <= 6'h3F;
        if (!ap_small && env_mode[4]) begin
          env_stop <= 1'b1;
          env_level <= env_mode[5] ? 4'd15 : 4'd0;
        end else begin
          env_cnt <= ap_cnt;
          env_mode <= ap_mode;
          env_level <= ap_level;
        end
      end
      if (cmd.wr_reg) begin
        regs[idx_r] <= val_r;
        case (kind)
          psgpc_pkg::RK_MIXER: mask <= 6'((cur ^ val_r) & 8'h3F);
          psgpc_pkg::RK_VOL: begin
            case (idx_r)
              psgpc_pkg::REG_VOL_A: mask <= 6'h09;
              psgpc_pkg::REG_VOL_C: mask <= 6'h24;
              default: mask <= 6'h12;
            endcase
          end
          psgpc_pkg::RK_PERIOD: env_period <= {pm[19:0], 4'd0};
          psgpc_pkg::RK_SHAPE: begin
            env_mode <= psgpc_pkg::shape_lookup(val_r[3:0]);
            env_cnt <= 4'd15;
            env_stop <= 1'b0;
            env_level <= 4'(~psgpc_pkg::shape_lookup(val_r[3:0]));
            last_clock <= now_r;
            mask <= 6'h3F;
          end
          default: ;
        endcase
      end
      if (cmd.eval && sts.eval_hit) begin
        chlev[cmd.lane] <= lane_v;
        if (cmd.lane == 2'd2) begin
          wave_bank <= (lane_v == 4'd0) ? 1'b0 : ~wave_bank;
        end
      end
      if (cmd.emit) begin
        if (cmd.code == psgpc_pkg::EM_NEW_FREQ) begin
          cfreq[cmd.lane] <= new_freq;
        end
        if (qcnt < 5'(psgpc_pkg::QDEPTH)) begin
          qcnt <= qcnt + 5'd1;
        end
      end
      if (cmd.drain && rd < qcnt) begin
        rd <= rd + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r <= operation;
      idx_r <= reg_index;
      val_r <= reg_value;
      now_r <= now;
    end
    if (cmd.tone_mul) begin
      prod <= {17'd0, f_hi[3:0], f_lo} * {12'd0, psgpc_pkg::TONE_SCALE};
    end
    if (cmd.emit && qcnt < 5'(psgpc_pkg::QDEPTH)) begin
      qt[qcnt] <= e_tgt;
      qd[qcnt] <= e_dat;
    end
    if (cmd.drain && rd < qcnt) begin
      target <= qt[rd];
      data <= qd[rd];
      last <= (rd + 5'd1 == qcnt);
    end
  end

endmodule

// ----- hw/rtl/psgpc_ctrl.sv -----
module psgpc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  output psgpc_pkg::cmd_t cmd,
  input  psgpc_pkg::sts_t sts
);

  psgpc_pkg::state_t state, state_next;
  logic [1:0] lane, lane_next;
  logic [2:0] step, step_next;
  logic       pend, pend_next;
  logic       emit_end;

  assign busy = (state != psgpc_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psgpc_pkg::S_IDLE;
      lane <= 2'd0;
      step <= 3'd0;
      pend <= 1'b0;
    end else begin
      state <= state_next;
      lane <= lane_next;
      step <= step_next;
      pend <= pend_next;
    end
  end

  always_comb begin
    state_next = state;
    lane_next = lane;
    step_next = step;
    pend_next = pend;
    cmd = '0;
    cmd.lane = lane;
    cmd.code = psgpc_pkg::EM_LEVEL;
    emit_end = 1'b0;

    unique case (state)
      psgpc_pkg::S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_next = psgpc_pkg::S_CHECK;
        end
      end
      psgpc_pkg::S_CHECK: begin
        if (sts.is_sync) begin
          pend_next = 1'b0;
          state_next = psgpc_pkg::S_SYNC;
        end else if (sts.ignore) begin
          state_next = psgpc_pkg::S_DRAIN;
        end else begin
          pend_next = 1'b1;
          state_next = psgpc_pkg::S_SYNC;
        end
      end
      psgpc_pkg::S_SYNC: begin
        if (sts.sync_need) begin
          cmd.div_start = 1'b1;
          state_next = psgpc_pkg::S_DIV;
        end else begin
          state_next = pend ? psgpc_pkg::S_WRITE : psgpc_pkg::S_DRAIN;
        end
      end
      psgpc_pkg::S_DIV: begin
        if (sts.div_done) begin
          state_next = psgpc_pkg::S_APPLY;
        end
      end
      psgpc_pkg::S_APPLY: begin
        cmd.apply_sync = 1'b1;
        lane_next = 2'd0;
        state_next = psgpc_pkg::S_EVAL;
      end
      psgpc_pkg::S_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.eval_hit) begin
          step_next = 3'd0;
          state_next = psgpc_pkg::S_EMIT;
        end else if (lane == 2'd3) begin
          state_next = pend ? psgpc_pkg::S_WRITE : psgpc_pkg::S_DRAIN;
        end else begin
          lane_next = lane + 2'd1;
        end
      end
      psgpc_pkg::S_EMIT: begin
        cmd.emit = 1'b1;
        if (lane != 2'd2) begin
          cmd.code = (step == 3'd0) ? psgpc_pkg::EM_LEVEL : psgpc_pkg::EM_FREQ;
          emit_end = (step == 3'd1);
        end else if (sts.lvl2_zero) begin
          cmd.code = psgpc_pkg::EM_CTL_OFF;
          emit_end = 1'b1;
        end else begin
          case (step)
            3'd0: cmd.code = psgpc_pkg::EM_WAVE0;
            3'd1: cmd.code = psgpc_pkg::EM_WAVE1;
            3'd2: cmd.code = psgpc_pkg::EM_WAVE2;
            3'd3: cmd.code = psgpc_pkg::EM_WAVE3;
            3'd4: cmd.code = psgpc_pkg::EM_CTL_ON;
            default: cmd.code = psgpc_pkg::EM_FREQ;
          endcase
          emit_end = (step == 3'd5);
        end
        if (!emit_end) begin
          step_next = step + 3'd1;
        end else if (lane == 2'd3) begin
          state_next = pend ? psgpc_pkg::S_WRITE : psgpc_pkg::S_DRAIN;
        end else begin
          lane_next = lane + 2'd1;
          state_next = psgpc_pkg::S_EVAL;
        end
      end
      psgpc_pkg::S_WRITE: begin
        cmd.wr_reg = 1'b1;
        pend_next = 1'b0;
        lane_next = 2'd0;
        case (sts.kind)
          psgpc_pkg::RK_TONE: state_next = psgpc_pkg::S_TONE_MUL;
          psgpc_pkg::RK_NOISE: state_next = psgpc_pkg::S_NOISE_SET;
          psgpc_pkg::RK_MIXER, psgpc_pkg::RK_VOL, psgpc_pkg::RK_SHAPE:
            state_next = psgpc_pkg::S_EVAL;
          default: state_next = psgpc_pkg::S_DRAIN;
        endcase
      end
      psgpc_pkg::S_TONE_MUL: begin
        cmd.tone_mul = 1'b1;
        state_next = psgpc_pkg::S_TONE_SET;
      end
      psgpc_pkg::S_TONE_SET: begin
        cmd.emit = 1'b1;
        cmd.code = psgpc_pkg::EM_NEW_FREQ;
        cmd.lane = sts.tone_lane;
        state_next = psgpc_pkg::S_DRAIN;
      end
      psgpc_pkg::S_NOISE_SET: begin
        cmd.emit = 1'b1;
        cmd.code = psgpc_pkg::EM_NEW_FREQ;
        cmd.lane = 2'd3;
        state_next = psgpc_pkg::S_DRAIN;
      end
      psgpc_pkg::S_DRAIN: begin
        cmd.drain = 1'b1;
        if (sts.drain_end) begin
          state_next = psgpc_pkg::S_IDLE;
        end
      end
      default: state_next = psgpc_pkg::S_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/psg_to_pulse_channel_translator.sv -----
// Channel   Direction  Signals                                   Handshake
// command   in         operation, reg_index, reg_value, now      start, busy
// result    out        target, data, last                        strobe
// config    in         cfg_data (clock_multiple)                 cfg_valid, cfg_ready
//
// An item that is dropped goes straight to draining. Otherwise the envelope
// advances first when it must (through the divider), then channels are
// evaluated and words queued for them, then the words go out on the result port.
// The worst case, a shape write that advances the envelope, queues 24 words.
// Reset is synchronous and needs no clearing pass.
// Results are strobed one per cycle once the item's words are queued; the receiver
// cannot stall them. Configuration is always ready.
module psg_to_pulse_channel_translator (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        operation,
  input  logic [3:0]  reg_index,
  input  logic [7:0]  reg_value,
  input  logic [31:0] now,
  output logic        strobe,
  output logic [3:0]  target,
  output logic [31:0] data,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);

  psgpc_pkg::cmd_t cmd;
  psgpc_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  psgpc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  psgpc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .operation (operation),
    .reg_index (reg_index),
    .reg_value (reg_value),
    .now       (now),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .strobe    (strobe),
    .target    (target),
    .data      (data),
    .last      (last)
  );

endmodule
